// File: rtl/core/dawd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dawd_pkg
// shared types, constants and calendar helpers for the date advance block
// ----------------------------------------------------------------------------
package dawd_pkg;

    localparam int ADD_WIDTH_DEF = 16;
    localparam int SERIAL_W      = 22;

    localparam logic [13:0] MAX_YEAR   = 14'd9999;
    localparam logic [3:0]  LAST_MONTH = 4'd12;
    localparam logic [4:0]  LAST_DAY   = 5'd31;
    localparam logic [6:0]  LAST_CENT  = 7'd99;

    // reciprocal of 100, exact for years below 43690
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int          RECIP_100_SHR = 19;

    localparam logic [8:0] YEAR_LEN      = 9'd365;
    localparam logic [8:0] LEAP_YEAR_LEN = 9'd366;
    localparam logic [4:0] FEB_LEAP_LEN  = 5'd29;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // days before the first of each month in a common year
    localparam logic [8:0] CUM_DAYS [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // month and year with the year split as q100 * 100 + r100
    typedef struct packed {
        logic [3:0]  month;
        logic [13:0] year;
        logic [6:0]  r100;
        logic [6:0]  q100;
    } t_cal;

    typedef struct packed {
        logic adv;
        logic ovf;
    } t_step_ctl;

    function automatic logic is_leap(input logic [1:0] y_lo, input logic [6:0] r100,
                                     input logic [1:0] q_lo);
        return (y_lo == 2'd0) && ((r100 != 7'd0) || (q_lo == 2'd0));
    endfunction

    // 8 == 1 mod 7, so octal digits fold down
    function automatic logic [2:0] mod7(input logic [SERIAL_W-1:0] v);
        logic [23:0] x;
        logic [5:0]  s1;
        logic [3:0]  s2;
        logic [3:0]  s3;
        x  = 24'(v);
        s1 = 6'd0;
        for (int i = 0; i < 8; i++) begin
            s1 = s1 + 6'(x[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        return (s3 == 4'd7) ? 3'd0 : s3[2:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/dawd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dawd_in_if
// start date and day count channel
// ----------------------------------------------------------------------------
interface dawd_in_if #(
    parameter int ADD_WIDTH = dawd_pkg::ADD_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [4:0]           start_day;
    logic [3:0]           start_month;
    logic [13:0]          start_year;
    logic [ADD_WIDTH-1:0] add_days;

    modport source (output valid, output start_day, output start_month,
                    output start_year, output add_days, input ready);
    modport sink   (input valid, input start_day, input start_month,
                    input start_year, input add_days, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dawd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dawd_out_if
// resulting date, weekday and overflow channel
// ----------------------------------------------------------------------------
interface dawd_out_if ();
    logic        valid;
    logic        ready;
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [2:0]  weekday;
    logic        overflow;

    modport source (output valid, output result_day, output result_month,
                    output result_year, output weekday, output overflow, input ready);
    modport sink   (input valid, input result_day, input result_month,
                    input result_year, input weekday, input overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dawd_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dawd_step
// one month or one whole year of date advance: compare, subtract, roll over
// ----------------------------------------------------------------------------
module dawd_step #(
    parameter int ADD_WIDTH = dawd_pkg::ADD_WIDTH_DEF
) (
    input  wire logic [ADD_WIDTH:0] i_day,
    input  wire dawd_pkg::t_cal     i_cal,
    output logic [ADD_WIDTH:0]      o_day,
    output dawd_pkg::t_cal          o_cal,
    output dawd_pkg::t_step_ctl     o_ctl
);
    localparam int DW = ADD_WIDTH + 1;

    logic          w_leap;
    logic [8:0]    w_ylen;
    logic [4:0]    w_dim;
    logic          w_year_skip;
    logic [DW-1:0] w_sub;
    logic [DW:0]   w_diff;
    logic          w_adv;
    logic          w_inc_year;

    always_comb begin
        w_leap = dawd_pkg::is_leap(i_cal.year[1:0], i_cal.r100, i_cal.q100[1:0]);
        w_ylen = w_leap ? dawd_pkg::LEAP_YEAR_LEN : dawd_pkg::YEAR_LEN;
        if ((i_cal.month == 4'd2) && w_leap) begin
            w_dim = dawd_pkg::FEB_LEAP_LEN;
        end else begin
            w_dim = dawd_pkg::MONTH_LEN[i_cal.month - 4'd1];
        end
        // from january a whole year goes at once when it fits
        w_year_skip = (i_cal.month == 4'd1) && (i_day > DW'(w_ylen));
        w_sub       = w_year_skip ? DW'(w_ylen) : DW'(w_dim);
        w_diff      = {1'b0, i_day} - {1'b0, w_sub};
        w_adv       = !w_diff[DW] && (w_diff[DW-1:0] != '0);
        w_inc_year  = w_year_skip || (i_cal.month == dawd_pkg::LAST_MONTH);
    end

    always_comb begin
        o_day = w_diff[DW-1:0];
        o_cal = i_cal;
        if (w_year_skip) begin
            o_cal.month = 4'd1;
        end else if (i_cal.month == dawd_pkg::LAST_MONTH) begin
            o_cal.month = 4'd1;
        end else begin
            o_cal.month = i_cal.month + 4'd1;
        end
        if (w_inc_year) begin
            o_cal.year = i_cal.year + 14'd1;
            if (i_cal.r100 == dawd_pkg::LAST_CENT) begin
                o_cal.r100 = 7'd0;
                o_cal.q100 = i_cal.q100 + 7'd1;
            end else begin
                o_cal.r100 = i_cal.r100 + 7'd1;
            end
        end
        o_ctl.adv = w_adv;
        o_ctl.ovf = w_adv && w_inc_year && (i_cal.year == dawd_pkg::MAX_YEAR);
    end

endmodule
`default_nettype wire

// File: rtl/core/date_add_days_with_weekday.sv
`default_nettype none
// ----------------------------------------------------------------------------
// date_add_days_with_weekday
// gregorian date advance by a day count, with weekday and year saturation
// ----------------------------------------------------------------------------
// usage
//   i_in carries start_day, start_month, start_year and add_days; a transfer
//   happens when valid and ready are both high. o_out carries result_day,
//   result_month, result_year, weekday (0 sunday) and overflow.
//   out-of-range start fields are clamped; a start day beyond the month
//   length rolls forward like added days.
//   after the input transfer the sequencer splits the year (init1, init2),
//   then makes step-unit passes in the run state: one per month, or one per
//   whole year when the date stands in january, bounded by the year 9999
//   limit; it then works out the weekday (wk1, wk2, wk3) and waits in hold.
//   the shared compare/subtract step unit makes every one of those passes.
//   one item is in work at a time; i_in.ready is high only while idle.
//   the result sits in an output register, so a new item is taken while a
//   finished result still waits; if the receiver stalls, the next result
//   holds in the sequencer until the output register frees.
//   reset (synchronous, active low) empties the output register and returns
//   the sequencer to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module date_add_days_with_weekday #(
    parameter int ADD_WIDTH = dawd_pkg::ADD_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dawd_in_if.sink    i_in,
    dawd_out_if.source o_out
);
    localparam int DW = ADD_WIDTH + 1;
    localparam int SW = dawd_pkg::SERIAL_W;

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT1 = 3'd1;
    localparam logic [2:0] ST_INIT2 = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_WK1   = 3'd4;
    localparam logic [2:0] ST_WK2   = 3'd5;
    localparam logic [2:0] ST_WK3   = 3'd6;
    localparam logic [2:0] ST_HOLD  = 3'd7;

    logic [2:0]     r_state;
    logic [2:0]     n_state;
    logic [DW-1:0]  r_day;
    dawd_pkg::t_cal r_cal;
    logic           r_ovf;
    logic [SW-1:0]  r_acc;
    logic [2:0]     r_wk;

    logic        r_out_valid;
    logic [4:0]  r_out_day;
    logic [3:0]  r_out_month;
    logic [13:0] r_out_year;
    logic [2:0]  r_out_wk;
    logic        r_out_ovf;

    logic w_in_xfer;
    logic w_out_free;

    // clamped start fields
    logic [4:0]  w_s_day;
    logic [3:0]  w_s_month;
    logic [13:0] w_s_year;

    // step unit
    logic [DW-1:0]       w_n_day;
    dawd_pkg::t_cal      w_n_cal;
    dawd_pkg::t_step_ctl w_ctl;

    // year split and weekday terms
    logic [26:0] w_q_prod;
    logic [13:0] w_r_full;
    logic [13:0] w_p;
    logic [22:0] w_p365;
    logic [6:0]  w_p100;
    logic        w_leap;
    logic [SW-1:0] w_serial;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        w_s_day   = (i_in.start_day == 5'd0) ? 5'd1 : i_in.start_day;
        w_s_month = i_in.start_month;
        if (i_in.start_month == 4'd0) begin
            w_s_month = 4'd1;
        end else if (i_in.start_month > dawd_pkg::LAST_MONTH) begin
            w_s_month = dawd_pkg::LAST_MONTH;
        end
        w_s_year = i_in.start_year;
        if (i_in.start_year == 14'd0) begin
            w_s_year = 14'd1;
        end else if (i_in.start_year > dawd_pkg::MAX_YEAR) begin
            w_s_year = dawd_pkg::MAX_YEAR;
        end
    end

    dawd_step #(
        .ADD_WIDTH (ADD_WIDTH)
    ) u_step (
        .i_day (r_day),
        .i_cal (r_cal),
        .o_day (w_n_day),
        .o_cal (w_n_cal),
        .o_ctl (w_ctl)
    );

    // year / 100 by reciprocal, remainder by one constant product
    assign w_q_prod = {13'd0, r_cal.year} * {14'd0, dawd_pkg::RECIP_100};
    assign w_r_full = r_cal.year - (14'(r_cal.q100) * 14'd100);

    // serial day count of the result, 1 jan of year 1 being day 1
    assign w_p    = r_cal.year - 14'd1;
    assign w_p365 = {9'd0, w_p} * {14'd0, dawd_pkg::YEAR_LEN};
    assign w_p100 = (r_cal.r100 == 7'd0) ? (r_cal.q100 - 7'd1) : r_cal.q100;
    assign w_leap = dawd_pkg::is_leap(r_cal.year[1:0], r_cal.r100, r_cal.q100[1:0]);
    assign w_serial = w_p365[SW-1:0] + SW'(w_p[13:2]) + SW'(r_day[4:0])
                    + SW'(dawd_pkg::CUM_DAYS[r_cal.month - 4'd1])
                    + SW'(w_leap && (r_cal.month > 4'd2));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_xfer) n_state = ST_INIT1;
            ST_INIT1: n_state = ST_INIT2;
            ST_INIT2: n_state = ST_RUN;
            ST_RUN:   if (w_ctl.ovf || !w_ctl.adv) n_state = ST_WK1;
            ST_WK1:   n_state = ST_WK2;
            ST_WK2:   n_state = ST_WK3;
            ST_WK3:   n_state = ST_HOLD;
            ST_HOLD:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    r_day       <= DW'(w_s_day) + DW'(i_in.add_days);
                    r_cal.month <= w_s_month;
                    r_cal.year  <= w_s_year;
                    r_ovf       <= 1'b0;
                end
            end
            ST_INIT1: begin
                r_cal.q100 <= w_q_prod[dawd_pkg::RECIP_100_SHR +: 7];
            end
            ST_INIT2: begin
                r_cal.r100 <= w_r_full[6:0];
            end
            ST_RUN: begin
                if (w_ctl.ovf) begin
                    // saturate to the last day of the last year
                    r_day       <= DW'(dawd_pkg::LAST_DAY);
                    r_cal.month <= dawd_pkg::LAST_MONTH;
                    r_cal.year  <= dawd_pkg::MAX_YEAR;
                    r_cal.r100  <= dawd_pkg::LAST_CENT;
                    r_cal.q100  <= dawd_pkg::LAST_CENT;
                    r_ovf       <= 1'b1;
                end else if (w_ctl.adv) begin
                    r_day <= w_n_day;
                    r_cal <= w_n_cal;
                end
            end
            ST_WK1: begin
                r_acc <= w_serial;
            end
            ST_WK2: begin
                r_acc <= r_acc - SW'(w_p100) + SW'(w_p100[6:2]);
            end
            ST_WK3: begin
                r_wk <= dawd_pkg::mod7(r_acc);
            end
            ST_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_HOLD) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_HOLD) && w_out_free) begin
            r_out_day   <= r_day[4:0];
            r_out_month <= r_cal.month;
            r_out_year  <= r_cal.year;
            r_out_wk    <= r_wk;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_day   = r_out_day;
    assign o_out.result_month = r_out_month;
    assign o_out.result_year  = r_out_year;
    assign o_out.weekday      = r_out_wk;
    assign o_out.overflow     = r_out_ovf;

    // a transfer in always starts the year split
    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_INIT1))
        else $error("input transfer did not start the sequencer");

    // the year split stays consistent while stepping
    a_year_split : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |->
        (r_cal.year == (14'(r_cal.q100) * 14'd100) + 14'(r_cal.r100)))
        else $error("year split out of step with year");

    // an overflowed result is the saturated date
    a_ovf_saturates : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |->
        ((r_out_year == dawd_pkg::MAX_YEAR) && (r_out_month == dawd_pkg::LAST_MONTH)
         && (r_out_day == dawd_pkg::LAST_DAY)))
        else $error("overflow result is not saturated");

    // a finished result reaches the output once the register frees
    a_hold_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_HOLD) && w_out_free) |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("finished result not moved to the output register");

    // a result in work stays in the sequencer while the output stalls
    a_hold_waits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_HOLD) && !w_out_free) |=> (r_state == ST_HOLD))
        else $error("result left the sequencer during an output stall");

endmodule
`default_nettype wire
